@@ rtl/lwb_pkg.sv @@
// Shared types, character codes and column arithmetic for the line wrapper.
package lwb_pkg;

   localparam int COL_W      = 11;
   localparam int LINE_W     = 10;
   localparam int CSR_DATA_W = 10;
   localparam int CSR_IDX_W  = 1;
   localparam int TAB_STOP   = 8;

   localparam logic [COL_W-1:0]      COL_MAX    = 11'd2047;
   localparam logic [LINE_W-1:0]     DEF_WIDTH  = 10'd80;
   localparam logic [7:0]            CHAR_NL    = 8'd10;
   localparam logic [7:0]            CHAR_TAB   = 8'd9;
   localparam logic [7:0]            CHAR_SPACE = 8'd32;
   localparam logic [CSR_IDX_W-1:0]  REG_LINE_WIDTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0]  REG_WORD_BREAK = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] in_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   // Work left for the current word, in the order it is carried out.
   typedef struct packed {
      logic pre_nl;
      logic do_flush;
      logic post_nl;
      logic emit;
      logic store;
   } steps_type;

   function automatic logic [COL_W-1:0] col_sat(input logic [COL_W-1:0] a,
                                                input logic [COL_W-1:0] b);
      logic [COL_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[COL_W] ? COL_MAX : sum[COL_W-1:0];
   endfunction

   function automatic logic [COL_W-1:0] next_stop(input logic [COL_W-1:0] c);
      logic [COL_W-1:0] base;
      base = c - (c % COL_W'(TAB_STOP));
      return col_sat(base, COL_W'(TAB_STOP));
   endfunction

endpackage

@@ rtl/lwb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lwb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/lwb_plan.sv @@
// Decides the emission steps and the next column and held count for one word.
module lwb_plan #(
   parameter int WORD_CAP = 32
) (
   input  logic                          word_break,
   input  logic [lwb_pkg::LINE_W-1:0]    width,
   input  lwb_pkg::req_type              item,
   input  logic [lwb_pkg::COL_W-1:0]     column,
   input  logic [$clog2(WORD_CAP+1)-1:0] held,
   input  logic [lwb_pkg::COL_W-1:0]     col_f,
   input  logic                          sum_ge,
   output lwb_pkg::steps_type            steps,
   output logic [lwb_pkg::COL_W-1:0]     col_next,
   output logic [$clog2(WORD_CAP+1)-1:0] held_next,
   output logic [$clog2(WORD_CAP)-1:0]   wr_addr
);
   import lwb_pkg::*;

   localparam int HW = $clog2(WORD_CAP + 1);
   localparam int AW = $clog2(WORD_CAP);

   logic             is_nl;
   logic             is_tab;
   logic             is_blank;
   logic             nl;
   logic [COL_W-1:0] ns_f;
   logic [COL_W-1:0] width_c;

   assign is_nl    = item.in_byte == CHAR_NL;
   assign is_tab   = item.in_byte == CHAR_TAB;
   assign is_blank = is_tab || item.in_byte == CHAR_SPACE;
   assign ns_f     = next_stop(col_f);
   assign width_c  = COL_W'(width);

   always_comb begin
      steps     = '0;
      col_next  = column;
      held_next = held;
      wr_addr   = held[AW-1:0];
      nl        = 1'b0;
      if (item.kind) begin
         steps.do_flush = held != '0;
         col_next       = '0;
         held_next      = '0;
      end else if (is_nl) begin
         steps.do_flush = held != '0;
         steps.emit     = 1'b1;
         col_next       = '0;
         held_next      = '0;
      end else if (!word_break || is_blank) begin
         // The held word goes out first, so all checks use the column after it.
         steps.do_flush = held != '0;
         held_next      = '0;
         nl             = (!word_break && is_tab) ? (ns_f >= width_c) : (col_f >= width_c);
         steps.post_nl  = nl;
         steps.emit     = 1'b1;
         if (is_tab) begin
            col_next = nl ? COL_W'(TAB_STOP) : ns_f;
         end else begin
            col_next = nl ? COL_W'(1) : col_sat(col_f, COL_W'(1));
         end
      end else begin
         steps.pre_nl = sum_ge && column != '0;
         steps.store  = 1'b1;
         if (held >= HW'(WORD_CAP)) begin
            // Full store: the old word goes out and this byte starts a new one.
            steps.do_flush = 1'b1;
            col_next       = steps.pre_nl ? COL_W'(held) : col_f;
            held_next      = HW'(1);
            wr_addr        = '0;
         end else begin
            col_next  = steps.pre_nl ? '0 : column;
            held_next = held + HW'(1);
         end
      end
   end

endmodule

@@ rtl/line_wrap_byte_stream.sv @@
// Line wrapper top level: item sequencer, word store and output register.
// An item is taken when idle and planned in the next cycle; the sequencer then sends
// an inserted newline, the held word, a newline after it and the byte, each as needed;
// the held word comes one byte per cycle from the word store read port unless stalled.
// An item that emits nothing goes back to idle after planning or its store write.
// Reset clears column, held count and handshakes; width 80, plain mode; store not cleared.
module line_wrap_byte_stream #(
   parameter int WORD_CAP = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  lwb_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output lwb_pkg::rsp_type                 rsp_data,
   input  logic                             csr_write,
   input  logic [lwb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lwb_pkg::CSR_DATA_W-1:0]   csr_data
);
   import lwb_pkg::*;

   localparam int HW = $clog2(WORD_CAP + 1);
   localparam int AW = $clog2(WORD_CAP);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PLAN  = 3'd1;
   localparam logic [2:0] S_PRE   = 3'd2;
   localparam logic [2:0] S_FLUSH = 3'd3;
   localparam logic [2:0] S_NL    = 3'd4;
   localparam logic [2:0] S_BYTE  = 3'd5;
   localparam logic [2:0] S_STORE = 3'd6;

   logic [2:0]        state_ff, state_in;
   req_type           item_ff, item_in;
   logic [COL_W-1:0]  colf_ff, colf_in;
   logic              sumge_ff, sumge_in;
   logic [COL_W-1:0]  column_ff, column_in;
   logic [HW-1:0]     held_ff, held_in;
   steps_type         steps_ff, steps_in, steps_clr;
   logic [HW-1:0]     rem_ff, rem_in;
   logic [HW-1:0]     rd_left_ff, rd_left_in;
   logic [AW-1:0]     rd_ff, rd_in;
   logic              pend_ff, pend_in;
   logic [AW-1:0]     wr_addr_ff, wr_addr_in;
   logic [LINE_W-1:0] line_width_ff;
   logic              word_break_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [LINE_W-1:0] width_eff;
   steps_type         plan_steps;
   logic [COL_W-1:0]  plan_col;
   logic [HW-1:0]     plan_held;
   logic [AW-1:0]     plan_waddr;
   logic              can_load;
   logic              load;
   rsp_type           load_data;
   logic              issue;
   logic              move;
   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [7:0]        ram_rdata;
   logic [COL_W:0]    sum_wide;

   function automatic logic [2:0] choose(input steps_type s);
      if (s.pre_nl) begin
         return S_PRE;
      end else if (s.do_flush) begin
         return S_FLUSH;
      end else if (s.post_nl) begin
         return S_NL;
      end else if (s.emit) begin
         return S_BYTE;
      end else if (s.store) begin
         return S_STORE;
      end
      return S_IDLE;
   endfunction

   assign width_eff = (line_width_ff == '0) ? DEF_WIDTH : line_width_ff;
   assign can_load  = !rsp_valid_ff || rsp_ready;
   assign sum_wide  = {1'b0, column_ff} + (COL_W + 1)'(held_ff);

   lwb_plan #(.WORD_CAP(WORD_CAP)) u_plan (
      .word_break (word_break_ff),
      .width      (width_eff),
      .item       (item_ff),
      .column     (column_ff),
      .held       (held_ff),
      .col_f      (colf_ff),
      .sum_ge     (sumge_ff),
      .steps      (plan_steps),
      .col_next   (plan_col),
      .held_next  (plan_held),
      .wr_addr    (plan_waddr)
   );

   lwb_ram #(.WIDTH(8), .DEPTH(WORD_CAP)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (item_ff.in_byte),
      .rd_en   (issue),
      .rd_addr (rd_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in   = state_ff;
      item_in    = item_ff;
      colf_in    = colf_ff;
      sumge_in   = sumge_ff;
      column_in  = column_ff;
      held_in    = held_ff;
      steps_clr  = steps_ff;
      steps_in   = steps_ff;
      rem_in     = rem_ff;
      rd_left_in = rd_left_ff;
      rd_in      = rd_ff;
      pend_in    = pend_ff;
      wr_addr_in = wr_addr_ff;
      load       = 1'b0;
      load_data  = '0;
      issue      = 1'b0;
      move       = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = wr_addr_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               colf_in  = col_sat(column_ff, COL_W'(held_ff));
               sumge_in = sum_wide >= (COL_W + 1)'(width_eff);
               state_in = S_PLAN;
            end
         end
         S_PLAN: begin
            column_in  = plan_col;
            held_in    = plan_held;
            rem_in     = plan_steps.do_flush ? held_ff : '0;
            rd_left_in = plan_steps.do_flush ? held_ff : '0;
            rd_in      = '0;
            pend_in    = 1'b0;
            wr_addr_in = plan_waddr;
            steps_clr  = plan_steps;
            // Without a flush nothing reads the store, so the word can be written now.
            if (plan_steps.store && !plan_steps.do_flush) begin
               ram_we          = 1'b1;
               ram_waddr       = plan_waddr;
               steps_clr.store = 1'b0;
            end
            steps_in = steps_clr;
            state_in = choose(steps_clr);
         end
         S_PRE: begin
            if (can_load) begin
               load               = 1'b1;
               load_data.out_byte = CHAR_NL;
               load_data.last     = !(steps_ff.do_flush || steps_ff.post_nl || steps_ff.emit);
               steps_clr.pre_nl   = 1'b0;
               steps_in           = steps_clr;
               state_in           = choose(steps_clr);
            end
         end
         S_FLUSH: begin
            // The read data register holds a word until the output register takes it.
            move  = pend_ff && can_load;
            issue = rd_left_ff != '0 && (!pend_ff || can_load);
            if (issue) begin
               rd_in      = rd_ff + AW'(1);
               rd_left_in = rd_left_ff - HW'(1);
               pend_in    = 1'b1;
            end else if (move) begin
               pend_in = 1'b0;
            end
            if (move) begin
               load               = 1'b1;
               load_data.out_byte = ram_rdata;
               load_data.last     = rem_ff == HW'(1) && !(steps_ff.post_nl || steps_ff.emit);
               rem_in             = rem_ff - HW'(1);
               if (rem_ff == HW'(1)) begin
                  steps_clr.do_flush = 1'b0;
                  steps_in           = steps_clr;
                  state_in           = choose(steps_clr);
               end
            end
         end
         S_NL: begin
            if (can_load) begin
               load               = 1'b1;
               load_data.out_byte = CHAR_NL;
               load_data.last     = !steps_ff.emit;
               steps_clr.post_nl  = 1'b0;
               steps_in           = steps_clr;
               state_in           = choose(steps_clr);
            end
         end
         S_BYTE: begin
            if (can_load) begin
               load               = 1'b1;
               load_data.out_byte = item_ff.in_byte;
               load_data.last     = 1'b1;
               steps_clr.emit     = 1'b0;
               steps_in           = steps_clr;
               state_in           = choose(steps_clr);
            end
         end
         S_STORE: begin
            ram_we          = 1'b1;
            steps_clr.store = 1'b0;
            steps_in        = steps_clr;
            state_in        = choose(steps_clr);
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = load_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         column_ff     <= '0;
         held_ff       <= '0;
         steps_ff      <= '0;
         rem_ff        <= '0;
         rd_left_ff    <= '0;
         rd_ff         <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         line_width_ff <= DEF_WIDTH;
         word_break_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         column_ff    <= column_in;
         held_ff      <= held_in;
         steps_ff     <= steps_in;
         rem_ff       <= rem_in;
         rd_left_ff   <= rd_left_in;
         rd_ff        <= rd_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            unique case (csr_index)
               REG_LINE_WIDTH: line_width_ff <= csr_data[LINE_W-1:0];
               REG_WORD_BREAK: word_break_ff <= csr_data[0];
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      colf_ff     <= colf_in;
      sumge_ff    <= sumge_in;
      wr_addr_ff  <= wr_addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_idle_no_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!pend_ff && rd_left_ff == '0))
      else $error("word store read still open while idle");

   a_flush_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FLUSH) |-> (rem_ff == rd_left_ff + HW'(pend_ff)))
      else $error("flush word count out of step with reads");

   a_write_no_read: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (!pend_ff && !issue))
      else $error("word store written while a flush read is open");

   a_held_cap: assert property (@(posedge clock) disable iff (reset)
      held_ff <= HW'(WORD_CAP))
      else $error("held count beyond word store depth");

endmodule

@@ verif/lwb_checker.sv @@
// Checker for the line wrapper: tracks the configuration, predicts the output stream and compares it.
module lwb_checker #(
   parameter int WORD_CAP = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  lwb_pkg::req_type                 req_data,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  lwb_pkg::rsp_type                 rsp_data,
   input  logic                             csr_write,
   input  logic [lwb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lwb_pkg::CSR_DATA_W-1:0]   csr_data,
   output int                               fail_count,
   output int                               pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import lwb_pkg::*;

   logic [COL_W-1:0]  column;
   logic [5:0]        held;
   logic [7:0]        word_buf [WORD_CAP];
   logic [LINE_W-1:0] width_reg;
   logic              wrap_words;
   rsp_type           wrapped_q [$];

   function automatic logic [COL_W-1:0] col_plus(input logic [COL_W-1:0] c, input int n);
      int s;
      s = int'(c) + n;
      return (s > int'(COL_MAX)) ? COL_MAX : COL_W'(s);
   endfunction

   function automatic logic [COL_W-1:0] tab_target(input logic [COL_W-1:0] c);
      return col_plus(COL_W'((int'(c) / TAB_STOP) * TAB_STOP), TAB_STOP);
   endfunction

   function automatic void push_byte(input logic [7:0] b);
      wrapped_q.push_back('{out_byte: b, last: 1'b0});
   endfunction

   // Emits the held word and moves the column past it.
   function automatic void spill_word();
      for (int i = 0; i < int'(held); i++)
         push_byte(word_buf[i]);
      column = col_plus(column, int'(held));
      held = '0;
   endfunction

   function automatic void fold_byte(input req_type r);
      int               first;
      logic [COL_W-1:0] width;
      rsp_type          tail;
      first = wrapped_q.size();
      width = (width_reg == '0) ? COL_W'(DEF_WIDTH) : COL_W'(width_reg);
      if (r.kind) begin
         spill_word();
         column = '0;
      end else if (r.in_byte == CHAR_NL) begin
         spill_word();
         push_byte(CHAR_NL);
         column = '0;
      end else if (!wrap_words) begin
         // A word left over from word-break mode goes out before the byte.
         spill_word();
         if (r.in_byte == CHAR_TAB) begin
            if (tab_target(column) >= width) begin
               push_byte(CHAR_NL);
               column = '0;
            end
            push_byte(CHAR_TAB);
            column = tab_target(column);
         end else begin
            if (column >= width) begin
               push_byte(CHAR_NL);
               column = '0;
            end
            push_byte(r.in_byte);
            column = col_plus(column, 1);
         end
      end else if (r.in_byte == CHAR_SPACE || r.in_byte == CHAR_TAB) begin
         spill_word();
         if (column >= width) begin
            push_byte(CHAR_NL);
            column = '0;
         end
         push_byte(r.in_byte);
         column = (r.in_byte == CHAR_TAB) ? tab_target(column) : col_plus(column, 1);
      end else begin
         if (int'(column) + int'(held) >= int'(width) && column != '0) begin
            push_byte(CHAR_NL);
            column = '0;
         end
         if (int'(held) >= WORD_CAP)
            spill_word();
         word_buf[int'(held) % WORD_CAP] = r.in_byte;
         held = held + 6'd1;
      end
      if (wrapped_q.size() > first) begin
         tail = wrapped_q.pop_back();
         tail.last = 1'b1;
         wrapped_q.push_back(tail);
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         column = '0;
         held = '0;
         width_reg = DEF_WIDTH;
         wrap_words = 1'b0;
         wrapped_q.delete();
      end else begin
         if (csr_write) begin
            if (csr_index == REG_LINE_WIDTH)
               width_reg = csr_data[LINE_W-1:0];
            else if (csr_index == REG_WORD_BREAK)
               wrap_words = csr_data[0];
         end
         if (req_valid && req_ready)
            fold_byte(req_data);
         if (rsp_valid && rsp_ready) begin
            if (wrapped_q.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual byte %02h last %0b",
                        $time, rsp_data.out_byte, rsp_data.last);
               fail_count++;
            end else begin
               want = wrapped_q.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                           $time, want.out_byte, rsp_data.out_byte);
                  fail_count++;
               end
               if (rsp_data.last !== want.last) begin
                  $display("%0t: last mismatch, expected %0b, actual %0b",
                           $time, want.last, rsp_data.last);
                  fail_count++;
               end
            end
         end
      end
      pending = wrapped_q.size();
   end

endmodule

@@ verif/tb_top.sv @@
// Top of the line wrapper testbench: clock, reset, stimulus, output back-pressure and verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import lwb_pkg::*;

   localparam int LONG_HOLD = 300;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   int                    fail_count;
   int                    pending;
   bit                    gaps_on;
   int                    holds_asked;
   int                    holds_done;

   line_wrap_byte_stream dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   lwb_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   // Output side: random stalls, ready stretches, and a long hold-off when asked.
   initial begin
      rsp_ready = 1'b0;
      while (reset !== 1'b0)
         @(negedge clock);
      forever begin
         @(negedge clock);
         if (holds_done != holds_asked) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            holds_done++;
         end else if (gaps_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13) - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(0, 15)) @(negedge clock);
         end
      end
   end

   // Called and returns at a falling edge.
   task automatic send_word(input logic kind, input logic [7:0] b);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{kind: kind, in_byte: b};
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
   endtask

   // A word that emits nothing may still be in flight, so wait a few cycles more.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      drain();
      repeat (8) @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // Printable words split by blanks, newlines and stream ends, with some raw bytes mixed in.
   // Now and then a word is long enough to overflow the word store.
   task automatic random_text(input int count);
      int sent;
      int len;
      int pick;
      sent = 0;
      while (sent < count) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 8);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 5) == 0)
               send_word(1'b0, 8'($urandom_range(0, 255)));
            else
               send_word(1'b0, 8'($urandom_range(33, 126)));
         end
         sent += len;
         pick = $urandom_range(0, 19);
         if (pick < 12)
            send_word(1'b0, CHAR_SPACE);
         else if (pick < 15)
            send_word(1'b0, CHAR_TAB);
         else if (pick < 18)
            send_word(1'b0, CHAR_NL);
         else if (pick == 18)
            send_word(1'b1, 8'($urandom_range(0, 255)));
         if (pick != 19)
            sent++;
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      gaps_on   = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: byte extremes, tab, newline, and end of stream with nothing held.
      send_word(1'b0, 8'h00);
      send_word(1'b0, 8'hff);
      send_word(1'b0, CHAR_TAB);
      send_word(1'b0, CHAR_NL);
      send_word(1'b1, 8'h00);

      // Narrow plain mode: a wrap before a byte and before a tab.
      write_reg(REG_LINE_WIDTH, 3);
      send_word(1'b0, "a");
      send_word(1'b0, "b");
      send_word(1'b0, "c");
      send_word(1'b0, "d");
      send_word(1'b0, CHAR_TAB);

      // Word-break mode: wraps before words, blanks, newline and end of stream flushes.
      write_reg(REG_WORD_BREAK, 1);
      send_word(1'b0, "x");
      send_word(1'b0, "y");
      send_word(1'b0, CHAR_SPACE);
      send_word(1'b0, "l");
      send_word(1'b0, "n");
      send_word(1'b0, "g");
      send_word(1'b0, CHAR_TAB);
      send_word(1'b0, "q");
      send_word(1'b0, CHAR_NL);
      send_word(1'b0, "z");
      send_word(1'b1, 8'hff);

      // A word still held when word-break mode is turned off.
      send_word(1'b0, "w");
      send_word(1'b0, "v");
      write_reg(REG_WORD_BREAK, 0);
      send_word(1'b0, "k");
      send_word(1'b1, 8'h5a);

      write_reg(REG_WORD_BREAK, 1);
      write_reg(REG_LINE_WIDTH, 20);
      random_text(40);

      write_reg(REG_LINE_WIDTH, 1);
      random_text(25);

      // Hold the output off while words keep coming, then let everything drain mid-phase.
      write_reg(REG_LINE_WIDTH, 1023);
      holds_asked++;
      random_text(20);
      drain();
      random_text(15);

      // Zero width behaves as the default width.
      write_reg(REG_WORD_BREAK, 0);
      write_reg(REG_LINE_WIDTH, 0);
      random_text(30);

      write_reg(REG_LINE_WIDTH, $urandom_range(1, 12));
      random_text(30);

      write_reg(REG_WORD_BREAK, 1);
      write_reg(REG_LINE_WIDTH, $urandom_range(1, 1023));
      gaps_on = 1'b0;
      random_text(40);
      send_word(1'b1, 8'h00);

      drain();
      repeat (20) @(negedge clock);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
